@@ design/cvd_pkg.sv @@
// Shared types, constants and position helpers for the charlieplexed voltage display.
package cvd_pkg;

    localparam int PIN_W      = 7;   // charlieplex pins
    localparam int ROW_OUT_W  = 3;
    localparam int POS_W      = 5;
    localparam int VALUE_W    = 16;
    localparam int CMD_W      = 2;
    localparam int COUNT_W    = 8;
    localparam int DIGIT_SEGS = 7;
    localparam int NUM_DIGITS = 3;
    localparam int GLYPH_W    = 4;
    localparam int ROW_PINS   = 6;   // positions per row
    localparam logic [POS_W-1:0] POS_MAX = 5'd30;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [POS_W-1:0]   VOLT_MARK_RESET  = 5'd21;
    localparam logic [POS_W-1:0]   POINT_MARK_RESET = 5'd22;
    localparam logic [COUNT_W-1:0] REFRESH_RESET    = 8'd60;

    localparam logic [GLYPH_W-1:0] DASH_GLYPH = 4'd10;

    localparam logic [DIGIT_SEGS-1:0] SEG_FONT [11] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f, 7'h40
    };

    // reciprocal constants: floor(v*M >> S) is exact for any 16-bit v
    localparam logic [16:0] RECIP_10   = 17'd52429;
    localparam int          SHIFT_10   = 19;
    localparam logic [16:0] RECIP_100  = 17'd83887;
    localparam int          SHIFT_100  = 23;
    localparam logic [16:0] RECIP_1000 = 17'd67109;
    localparam int          SHIFT_1000 = 26;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_VALUE = 2'd1,
        CMD_DASH  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_VOLT_MARK  = 2'd0,
        REG_POINT_MARK = 2'd1,
        REG_REFRESH    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]   volt_mark_pos;
        logic [POS_W-1:0]   point_mark_pos;
        logic [COUNT_W-1:0] refresh_limit;
    } cfg_t;

    // row of a display position (p / 6)
    function automatic logic [2:0] pos_row(input logic [POS_W-1:0] p);
        logic [2:0] r;
        if (p >= 5'd30)      r = 3'd5;
        else if (p >= 5'd24) r = 3'd4;
        else if (p >= 5'd18) r = 3'd3;
        else if (p >= 5'd12) r = 3'd2;
        else if (p >= 5'd6)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    // pin of a display position: column, skipping the row's own pin
    function automatic logic [2:0] pos_pin(input logic [POS_W-1:0] p);
        logic [2:0]       r;
        logic [POS_W-1:0] col;
        r   = pos_row(p);
        col = p - (POS_W'(r) * 5'd6);
        return (col[2:0] < r) ? col[2:0] : col[2:0] + 3'd1;
    endfunction

endpackage

@@ design/cvd_if.sv @@
// Valid/ready channel interfaces: command words in, pin scan words out.
interface cvd_cmd_if;
    import cvd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [VALUE_W-1:0]   value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface cvd_scan_if;
    import cvd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [PIN_W-1:0]     pin_level;
    logic [PIN_W-1:0]     pin_enable;
    logic [ROW_OUT_W-1:0] row;

    modport source (output valid, output pin_level, output pin_enable, output row, input ready);
    modport sink   (input valid, input pin_level, input pin_enable, input row, output ready);
endinterface

@@ design/cvd_apb_regs.sv @@
// APB configuration registers: mark positions and forced refresh limit.
module cvd_apb_regs
    import cvd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [POS_W-1:0]   volt_mark_reg;
    logic [POS_W-1:0]   point_mark_reg;
    logic [COUNT_W-1:0] refresh_limit_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_mark_reg     <= VOLT_MARK_RESET;
            point_mark_reg    <= POINT_MARK_RESET;
            refresh_limit_reg <= REFRESH_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_VOLT_MARK:  volt_mark_reg     <= pwdata[POS_W-1:0];
                REG_POINT_MARK: point_mark_reg    <= pwdata[POS_W-1:0];
                REG_REFRESH:    refresh_limit_reg <= pwdata[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_VOLT_MARK:  prdata = APB_DATA_W'(volt_mark_reg);
            REG_POINT_MARK: prdata = APB_DATA_W'(point_mark_reg);
            REG_REFRESH:    prdata = APB_DATA_W'(refresh_limit_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.volt_mark_pos  = volt_mark_reg;
    assign cfg.point_mark_pos = point_mark_reg;
    assign cfg.refresh_limit  = refresh_limit_reg;

endmodule

@@ design/cvd_render.sv @@
// Frame redraw: splits the value into digits and paints glyphs and marks into the rows.
module cvd_render
    import cvd_pkg::*;
#(
    parameter int NUM_ROWS = 5
)
(
    input  logic [PIN_W-1:0]   frame_in  [NUM_ROWS],
    input  logic [VALUE_W-1:0] value,
    input  logic               dash,
    input  cfg_t               cfg,
    output logic [PIN_W-1:0]   frame_out [NUM_ROWS]
);

    logic [32:0]           prod10;
    logic [32:0]           prod100;
    logic [32:0]           prod1000;
    logic [12:0]           q10;
    logic [9:0]            q100;
    logic [6:0]            q1000;
    logic [VALUE_W-1:0]    rem_ones;
    logic [12:0]           rem_tens;
    logic [9:0]            rem_hund;
    logic [GLYPH_W-1:0]    digit [NUM_DIGITS];
    logic [DIGIT_SEGS-1:0] glyph [NUM_DIGITS];

    assign prod10   = 33'(value) * 33'(RECIP_10);
    assign prod100  = 33'(value) * 33'(RECIP_100);
    assign prod1000 = 33'(value) * 33'(RECIP_1000);
    assign q10      = 13'(prod10 >> SHIFT_10);
    assign q100     = 10'(prod100 >> SHIFT_100);
    assign q1000    = 7'(prod1000 >> SHIFT_1000);

    assign rem_ones = value - (VALUE_W'(q10) * 16'd10);
    assign rem_tens = q10 - (13'(q100) * 13'd10);
    assign rem_hund = q100 - (10'(q1000) * 10'd10);

    // digit 0 is hundreds (mod 10), digit 2 is ones
    assign digit[0] = rem_hund[GLYPH_W-1:0];
    assign digit[1] = rem_tens[GLYPH_W-1:0];
    assign digit[2] = rem_ones[GLYPH_W-1:0];

    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            glyph[d] = dash ? SEG_FONT[DASH_GLYPH] : SEG_FONT[digit[d]];
        end
    end

    always_comb
    begin
        logic [POS_W-1:0] p;
        logic [2:0]       pr;
        logic [2:0]       vrow;
        logic [2:0]       prow;
        logic             vok;
        logic             pok;

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            frame_out[r] = frame_in[r];
        end

        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            for (int s = 0; s < DIGIT_SEGS; s++)
            begin
                p  = POS_W'(d * DIGIT_SEGS + s);
                pr = pos_row(p);
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    if (pr == 3'(r))
                    begin
                        frame_out[r][r]          = 1'b0;
                        frame_out[r][pos_pin(p)] = glyph[d][s];
                    end
                end
            end
        end

        // marks land after the digits; point mark wins a shared position
        vrow = pos_row(cfg.volt_mark_pos);
        prow = pos_row(cfg.point_mark_pos);
        vok  = cfg.volt_mark_pos <= POS_MAX;
        pok  = cfg.point_mark_pos <= POS_MAX;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (vok && vrow == 3'(r))
            begin
                frame_out[r][r]                         = 1'b0;
                frame_out[r][pos_pin(cfg.volt_mark_pos)] = !dash;
            end
        end
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (pok && prow == 3'(r))
            begin
                frame_out[r][r]                          = 1'b0;
                frame_out[r][pos_pin(cfg.point_mark_pos)] = !dash;
            end
        end
    end

endmodule

@@ design/charlieplex_voltage_display_top.sv @@
// Top level of the charlieplexed three-digit voltage display driver.
//
// Takes one command word per cycle with no bubbles: a dash word, or a jumping
// or forced value word, updates the frame rows at the edge it is accepted, and
// a scan tick loads the output register with the current row's pin levels and
// enables, so a tick issued right after a redraw already sees the new frame.
// Throughput is one word per clock, limited only by the single output register:
// any word stalls while an earlier scan word is still held there and the sink
// is not ready. An accepted tick's scan word shows in the next cycle. Digits
// come from reciprocal multiplies on the value, all within the accepting cycle.
module charlieplex_voltage_display_top
    import cvd_pkg::*;
#(
    parameter int NUM_ROWS = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    cvd_cmd_if.sink               cmd,
    cvd_scan_if.source            scan,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int RW = $clog2(NUM_ROWS);

    cfg_t cfg;

    logic [PIN_W-1:0]     frame_reg [NUM_ROWS];
    logic [PIN_W-1:0]     frame_next [NUM_ROWS];
    logic [RW-1:0]        scan_row_reg;
    logic [VALUE_W-1:0]   last_value_reg;
    logic [COUNT_W-1:0]   stable_count_reg;
    logic [COUNT_W-1:0]   stable_count_next;
    logic                 out_valid_reg;
    logic [PIN_W-1:0]     pin_level_reg;
    logic [PIN_W-1:0]     pin_enable_reg;
    logic [ROW_OUT_W-1:0] row_reg;

    logic                 accept;
    cmd_t                 cmd_code;
    logic                 is_tick;
    logic                 is_value;
    logic                 is_dash;
    logic [VALUE_W:0]     v_ext;
    logic [VALUE_W:0]     last_ext;
    logic                 big_change;
    logic [COUNT_W-1:0]   count_inc;
    logic                 forced;
    logic                 draw;
    logic [PIN_W-1:0]     scan_word;

    cvd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cvd_render #(.NUM_ROWS(NUM_ROWS)) u_render (
        .frame_in  (frame_reg),
        .value     (cmd.value),
        .dash      (is_dash),
        .cfg       (cfg),
        .frame_out (frame_next)
    );

    assign cmd.ready = !out_valid_reg || scan.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign cmd_code  = cmd_t'(cmd.command);

    always_comb
    begin
        is_tick  = 1'b0;
        is_value = 1'b0;
        is_dash  = 1'b0;
        case (cmd_code)
            CMD_TICK:  is_tick  = 1'b1;
            CMD_VALUE: is_value = 1'b1;
            CMD_DASH:  is_dash  = 1'b1;
            default:   ;
        endcase
    end

    // redraw on a dash, on a jump of more than one count, or after too many quiet values
    assign v_ext      = {1'b0, cmd.value};
    assign last_ext   = {1'b0, last_value_reg};
    assign big_change = (v_ext > last_ext + 17'd1) || (last_ext > v_ext + 17'd1);
    assign count_inc  = stable_count_reg + 8'd1;
    assign forced     = count_inc > cfg.refresh_limit;
    assign draw       = accept && ((is_value && (big_change || forced)) || is_dash);

    always_comb
    begin
        stable_count_next = stable_count_reg;
        if (accept && is_value && !big_change)
        begin
            stable_count_next = forced ? '0 : count_inc;
        end
    end

    assign scan_word = frame_reg[scan_row_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                frame_reg[r] <= ~(PIN_W'(1) << r);
            end
            scan_row_reg     <= '0;
            last_value_reg   <= '0;
            stable_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (draw)
            begin
                frame_reg <= frame_next;
            end
            stable_count_reg <= stable_count_next;
            if (accept && is_value)
            begin
                last_value_reg <= cmd.value;
            end
            if (accept && is_tick)
            begin
                out_valid_reg <= 1'b1;
                scan_row_reg  <= (scan_row_reg == RW'(NUM_ROWS - 1)) ? '0 : scan_row_reg + 1'b1;
            end
            else if (scan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan word payload
    always_ff @(posedge clk)
    begin
        if (accept && is_tick)
        begin
            pin_level_reg  <= scan_word;
            pin_enable_reg <= scan_word | (PIN_W'(1) << scan_row_reg);
            row_reg        <= ROW_OUT_W'(scan_row_reg);
        end
    end

    assign scan.valid      = out_valid_reg;
    assign scan.pin_level  = pin_level_reg;
    assign scan.pin_enable = pin_enable_reg;
    assign scan.row        = row_reg;

endmodule
